// ----- hw/rtl/qstm_pkg.sv -----
// qstm_pkg: shared types and constants of the quaternion/scale/position to matrix block
// no dependencies
`default_nettype none

package qstm_pkg;

    typedef logic signed [15:0] t_q14;
    typedef logic signed [15:0] t_scl;
    typedef logic signed [31:0] t_q16;
    typedef logic signed [32:0] t_prod;
    typedef logic signed [33:0] t_term;
    typedef logic signed [49:0] t_mac;

    typedef struct packed {
        t_q16 z;
        t_q16 y;
        t_q16 x;
    } t_pos;

    localparam int NUM_ELEM  = 9;
    localparam int NUM_AXIS  = 3;
    localparam int DROP_BITS = 20;

    localparam t_term ONE_Q28 = t_term'(64'sd268435456);
    localparam t_q16  ONE_Q16 = t_q16'(32'sd65536);
    localparam t_q16  ZERO_Q16 = t_q16'(32'sd0);

    localparam logic [1:0] COL_X    = 2'd0;
    localparam logic [1:0] COL_Y    = 2'd1;
    localparam logic [1:0] COL_Z    = 2'd2;
    localparam logic [1:0] COL_LAST = 2'd3;

    // doubled quaternion products
    localparam int P_XX = 0;
    localparam int P_XY = 1;
    localparam int P_XZ = 2;
    localparam int P_YY = 3;
    localparam int P_YZ = 4;
    localparam int P_ZZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

endpackage

`default_nettype wire

// ----- hw/rtl/qstm_prod.sv -----
// qstm_prod: pipeline stages 1 and 2, doubled quaternion products and rotation terms
// depends on qstm_pkg
`default_nettype none

module qstm_prod (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  qstm_pkg::t_q14       i_quat_x,
    input  qstm_pkg::t_q14       i_quat_y,
    input  qstm_pkg::t_q14       i_quat_z,
    input  qstm_pkg::t_q14       i_quat_w,
    input  qstm_pkg::t_scl [2:0] i_scale,
    input  qstm_pkg::t_pos       i_pos,
    output logic                 o_valid,
    output qstm_pkg::t_term [8:0] o_term,
    output qstm_pkg::t_scl [2:0] o_scale,
    output qstm_pkg::t_pos       o_pos
);
    import qstm_pkg::*;

    logic              r_v1;
    logic              r_v2;
    t_prod [8:0]       r_prod;
    t_prod [8:0]       n_prod;
    t_scl  [2:0]       r_scale1;
    t_scl  [2:0]       r_scale2;
    t_pos              r_pos1;
    t_pos              r_pos2;
    t_term [8:0]       r_term;
    t_term [8:0]       n_term;

    function automatic t_prod dbl_mul(input t_q14 a, input t_q14 b);
        t_prod p;
        p = t_prod'(a) * t_prod'(b);
        return p <<< 1;
    endfunction

    always_comb begin
        n_prod[P_XX] = dbl_mul(i_quat_x, i_quat_x);
        n_prod[P_XY] = dbl_mul(i_quat_x, i_quat_y);
        n_prod[P_XZ] = dbl_mul(i_quat_x, i_quat_z);
        n_prod[P_YY] = dbl_mul(i_quat_y, i_quat_y);
        n_prod[P_YZ] = dbl_mul(i_quat_y, i_quat_z);
        n_prod[P_ZZ] = dbl_mul(i_quat_z, i_quat_z);
        n_prod[P_WX] = dbl_mul(i_quat_w, i_quat_x);
        n_prod[P_WY] = dbl_mul(i_quat_w, i_quat_y);
        n_prod[P_WZ] = dbl_mul(i_quat_w, i_quat_z);
    end

    // terms stored column-major, index col*3+row
    always_comb begin
        n_term[0] = ONE_Q28 - (t_term'(r_prod[P_YY]) + t_term'(r_prod[P_ZZ]));
        n_term[1] = t_term'(r_prod[P_XY]) + t_term'(r_prod[P_WZ]);
        n_term[2] = t_term'(r_prod[P_XZ]) - t_term'(r_prod[P_WY]);
        n_term[3] = t_term'(r_prod[P_XY]) - t_term'(r_prod[P_WZ]);
        n_term[4] = ONE_Q28 - (t_term'(r_prod[P_XX]) + t_term'(r_prod[P_ZZ]));
        n_term[5] = t_term'(r_prod[P_YZ]) + t_term'(r_prod[P_WX]);
        n_term[6] = t_term'(r_prod[P_XZ]) + t_term'(r_prod[P_WY]);
        n_term[7] = t_term'(r_prod[P_YZ]) - t_term'(r_prod[P_WX]);
        n_term[8] = ONE_Q28 - (t_term'(r_prod[P_XX]) + t_term'(r_prod[P_YY]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_scale1 <= i_scale;
            r_pos1   <= i_pos;
            r_term   <= n_term;
            r_scale2 <= r_scale1;
            r_pos2   <= r_pos1;
        end
    end

    assign o_valid = r_v2;
    assign o_term  = r_term;
    assign o_scale = r_scale2;
    assign o_pos   = r_pos2;

endmodule

`default_nettype wire

// ----- hw/rtl/qstm_scale.sv -----
// qstm_scale: pipeline stage 3, rotation terms times their column scale
// depends on qstm_pkg
`default_nettype none

module qstm_scale (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  qstm_pkg::t_term [8:0] i_term,
    input  qstm_pkg::t_scl [2:0]  i_scale,
    input  qstm_pkg::t_pos        i_pos,
    output logic                  o_valid,
    output qstm_pkg::t_mac [8:0]  o_mac,
    output qstm_pkg::t_pos        o_pos
);
    import qstm_pkg::*;

    logic        r_v3;
    t_mac [8:0]  r_mac;
    t_mac [8:0]  n_mac;
    t_pos        r_pos3;

    always_comb begin
        for (int c = 0; c < NUM_AXIS; c++) begin
            for (int r = 0; r < NUM_AXIS; r++) begin
                n_mac[c*NUM_AXIS + r] = t_mac'(i_term[c*NUM_AXIS + r]) * t_mac'(i_scale[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mac  <= n_mac;
            r_pos3 <= i_pos;
        end
    end

    assign o_valid = r_v3;
    assign o_mac   = r_mac;
    assign o_pos   = r_pos3;

endmodule

`default_nettype wire

// ----- hw/rtl/qstm_colser.sv -----
// qstm_colser: holds one finished matrix and sends it out one column word at a time
// depends on qstm_pkg
`default_nettype none

module qstm_colser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  qstm_pkg::t_mac [8:0] i_mac,
    input  qstm_pkg::t_pos       i_pos,
    output logic                 o_load,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_column_index,
    output qstm_pkg::t_q16       o_row0,
    output qstm_pkg::t_q16       o_row1,
    output qstm_pkg::t_q16       o_row2,
    output qstm_pkg::t_q16       o_row3,
    output logic                 o_last_column
);
    import qstm_pkg::*;

    logic        r_valid;
    logic [1:0]  r_col;
    t_q16 [8:0]  r_mat;
    t_q16 [8:0]  n_mat;
    t_pos        r_pos;
    logic        take;

    assign take   = r_valid && !i_stall;
    assign o_load = i_valid && (!r_valid || (take && r_col == COL_LAST));

    // floor by dropping low bits; the 30-bit result always fits Q16.16
    always_comb begin
        for (int i = 0; i < NUM_ELEM; i++) begin
            n_mat[i] = t_q16'($signed(i_mac[i][49:DROP_BITS]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= COL_X;
        end else if (o_load) begin
            r_valid <= 1'b1;
            r_col   <= COL_X;
        end else if (take) begin
            r_valid <= (r_col != COL_LAST);
            r_col   <= r_col + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_mat <= n_mat;
            r_pos <= i_pos;
        end
    end

    always_comb begin
        case (r_col)
            COL_X: begin
                o_row0 = r_mat[0];
                o_row1 = r_mat[1];
                o_row2 = r_mat[2];
                o_row3 = ZERO_Q16;
            end
            COL_Y: begin
                o_row0 = r_mat[3];
                o_row1 = r_mat[4];
                o_row2 = r_mat[5];
                o_row3 = ZERO_Q16;
            end
            COL_Z: begin
                o_row0 = r_mat[6];
                o_row1 = r_mat[7];
                o_row2 = r_mat[8];
                o_row3 = ZERO_Q16;
            end
            default: begin
                o_row0 = r_pos.x;
                o_row1 = r_pos.y;
                o_row2 = r_pos.z;
                o_row3 = ONE_Q16;
            end
        endcase
    end

    assign o_valid        = r_valid;
    assign o_column_index = r_col;
    assign o_last_column  = (r_col == COL_LAST);

endmodule

`default_nettype wire

// ----- hw/rtl/quaternion_scale_translate_to_matrix.sv -----
// quaternion_scale_translate_to_matrix: top level, quaternion + scale + position to 4x4 TRS
// depends on qstm_pkg, qstm_prod, qstm_scale, qstm_colser
//
//   channel | direction | handshake           | word
//   input   | in        | i_valid / o_stall   | quaternion Q2.14, scale Q8.8, position Q16.16
//   output  | out       | o_valid / i_stall   | one matrix column, Q16.16, last on column 3
//
// three pipeline stages (products, terms, scaling) feed a column register that
// emits four words per item, one per cycle while i_stall is low, and loads the next
// matrix as its last column is taken. reset clears only the valid bits and the
// column index. the pipeline holds while its last stage waits for the column
// register, so an output stall backs up into o_stall.
`default_nettype none

module quaternion_scale_translate_to_matrix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  qstm_pkg::t_q14        i_quat_x,
    input  qstm_pkg::t_q14        i_quat_y,
    input  qstm_pkg::t_q14        i_quat_z,
    input  qstm_pkg::t_q14        i_quat_w,
    input  qstm_pkg::t_scl        i_scale_x,
    input  qstm_pkg::t_scl        i_scale_y,
    input  qstm_pkg::t_scl        i_scale_z,
    input  qstm_pkg::t_q16        i_pos_x,
    input  qstm_pkg::t_q16        i_pos_y,
    input  qstm_pkg::t_q16        i_pos_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_column_index,
    output qstm_pkg::t_q16        o_row0,
    output qstm_pkg::t_q16        o_row1,
    output qstm_pkg::t_q16        o_row2,
    output qstm_pkg::t_q16        o_row3,
    output logic                  o_last_column
);
    import qstm_pkg::*;

    logic         en;
    logic         load;
    logic         v2;
    logic         v3;
    t_scl [2:0]   scale_in;
    t_pos         pos_in;
    t_term [8:0]  term2;
    t_scl [2:0]   scale2;
    t_pos         pos2;
    t_mac [8:0]   mac3;
    t_pos         pos3;

    assign scale_in = {i_scale_z, i_scale_y, i_scale_x};
    assign pos_in   = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};

    // pipeline moves unless the last stage holds a matrix the column register cannot take
    assign en      = !v3 || load;
    assign o_stall = !en;

    qstm_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_quat_x(i_quat_x),
        .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z),
        .i_quat_w(i_quat_w),
        .i_scale (scale_in),
        .i_pos   (pos_in),
        .o_valid (v2),
        .o_term  (term2),
        .o_scale (scale2),
        .o_pos   (pos2)
    );

    qstm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_term  (term2),
        .i_scale (scale2),
        .i_pos   (pos2),
        .o_valid (v3),
        .o_mac   (mac3),
        .o_pos   (pos3)
    );

    qstm_colser u_colser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (v3),
        .i_mac         (mac3),
        .i_pos         (pos3),
        .o_load        (load),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_column_index(o_column_index),
        .o_row0        (o_row0),
        .o_row1        (o_row1),
        .o_row2        (o_row2),
        .o_row3        (o_row3),
        .o_last_column (o_last_column)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/qstm_chk.sv -----
// qstm_chk: port-level checks on the column output of the matrix block, bound to the top
// depends on qstm_pkg and quaternion_scale_translate_to_matrix
`default_nettype none

module qstm_chk (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  logic [1:0]            o_column_index,
    input  qstm_pkg::t_q16        o_row3,
    input  logic                  o_last_column
);
    import qstm_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    a_col_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_column_index != COL_LAST |=>
            o_valid && o_column_index == $past(o_column_index) + 2'd1)
        else $error("matrix columns not back to back in order");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_column == (o_column_index == COL_LAST)))
        else $error("last flag does not match column");

    a_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row3 == ((o_column_index == COL_LAST) ? ONE_Q16 : ZERO_Q16)))
        else $error("bottom row element wrong");

endmodule

bind quaternion_scale_translate_to_matrix qstm_chk u_qstm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_column_index(o_column_index),
    .o_row3        (o_row3),
    .o_last_column (o_last_column)
);

`default_nettype wire

// ----- test/quaternion_scale_translate_to_matrix_test.sv -----
// testbench for quaternion_scale_translate_to_matrix: directed table, then random poses,
// every word checked against typed rows or an in-bench predictor, random gaps and stalls
// depends on qstm_pkg and the quaternion_scale_translate_to_matrix rtl
`default_nettype none

module quaternion_scale_translate_to_matrix_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qstm_pkg::*;

    localparam int     RANDOM_POSES = 254;
    localparam int     IDLE_LIMIT   = 2000;
    localparam int     DRAIN_CYCLES = 16;
    localparam longint UNIT_Q28     = 64'sd268435456;
    localparam longint Q16_MAX      = 64'sd2147483647;
    localparam longint Q16_MIN      = -64'sd2147483648;

    typedef struct {
        t_q14 qx;
        t_q14 qy;
        t_q14 qz;
        t_q14 qw;
        t_scl sx;
        t_scl sy;
        t_scl sz;
        t_q16 px;
        t_q16 py;
        t_q16 pz;
    } pose_item;

    typedef struct {
        pose_item pose;
        bit       typed;
        t_q16     diag[3];
    } pose_row;

    typedef struct {
        logic [1:0] column;
        t_q16       row0;
        t_q16       row1;
        t_q16       row2;
        t_q16       row3;
        logic       last;
    } matrix_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_q14       i_quat_x;
    t_q14       i_quat_y;
    t_q14       i_quat_z;
    t_q14       i_quat_w;
    t_scl       i_scale_x;
    t_scl       i_scale_y;
    t_scl       i_scale_z;
    t_q16       i_pos_x;
    t_q16       i_pos_y;
    t_q16       i_pos_z;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [1:0] o_column_index;
    t_q16       o_row0;
    t_q16       o_row1;
    t_q16       o_row2;
    t_q16       o_row3;
    logic       o_last_column;

    matrix_word words_due[$];
    pose_row    directed_rows[$];
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    int         stall_left = 0;
    bit         quiet = 1'b0;

    quaternion_scale_translate_to_matrix dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 63) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 255) - 128);
            default: return $urandom;
        endcase
    endfunction

    function automatic pose_item random_pose();
        pose_item it;
        it.qx = pick16();
        it.qy = pick16();
        it.qz = pick16();
        it.qw = pick16();
        it.sx = pick16();
        it.sy = pick16();
        it.sz = pick16();
        it.px = pick32();
        it.py = pick32();
        it.pz = pick32();
        return it;
    endfunction

    function automatic t_q16 scale_term(longint term, longint s);
        longint q;
        q = (term * s) >>> DROP_BITS;
        if (q > Q16_MAX) q = Q16_MAX;
        if (q < Q16_MIN) q = Q16_MIN;
        return t_q16'(q);
    endfunction

    // rot[c][r]: column c, row r of the scaled rotation
    function automatic void push_matrix(pose_item it, t_q16 rot[3][3]);
        matrix_word wd;
        for (int c = 0; c < 3; c++) begin
            wd.column = 2'(c);
            wd.row0   = rot[c][0];
            wd.row1   = rot[c][1];
            wd.row2   = rot[c][2];
            wd.row3   = ZERO_Q16;
            wd.last   = 1'b0;
            words_due.push_back(wd);
        end
        wd.column = COL_LAST;
        wd.row0   = it.px;
        wd.row1   = it.py;
        wd.row2   = it.pz;
        wd.row3   = ONE_Q16;
        wd.last   = 1'b1;
        words_due.push_back(wd);
    endfunction

    function automatic void predict_matrix(pose_item it);
        longint x, y, z, w, sx, sy, sz;
        longint xx, xy, xz, yy, yz, zz, wx, wy, wz;
        t_q16   rot[3][3];
        x  = it.qx;
        y  = it.qy;
        z  = it.qz;
        w  = it.qw;
        sx = it.sx;
        sy = it.sy;
        sz = it.sz;
        xx = 2 * x * x;
        xy = 2 * x * y;
        xz = 2 * x * z;
        yy = 2 * y * y;
        yz = 2 * y * z;
        zz = 2 * z * z;
        wx = 2 * w * x;
        wy = 2 * w * y;
        wz = 2 * w * z;
        rot[0][0] = scale_term(UNIT_Q28 - (yy + zz), sx);
        rot[0][1] = scale_term(xy + wz, sx);
        rot[0][2] = scale_term(xz - wy, sx);
        rot[1][0] = scale_term(xy - wz, sy);
        rot[1][1] = scale_term(UNIT_Q28 - (xx + zz), sy);
        rot[1][2] = scale_term(yz + wx, sy);
        rot[2][0] = scale_term(xz + wy, sz);
        rot[2][1] = scale_term(yz - wx, sz);
        rot[2][2] = scale_term(UNIT_Q28 - (xx + yy), sz);
        push_matrix(it, rot);
    endfunction

    function automatic void push_typed(pose_row row);
        t_q16 rot[3][3];
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                rot[c][r] = (c == r) ? row.diag[c] : ZERO_Q16;
            end
        end
        push_matrix(row.pose, rot);
    endfunction

    task automatic add_row(input t_q14 qx, input t_q14 qy, input t_q14 qz, input t_q14 qw,
                           input t_scl sx, input t_scl sy, input t_scl sz,
                           input t_q16 px, input t_q16 py, input t_q16 pz,
                           input bit typed, input t_q16 d0, input t_q16 d1, input t_q16 d2);
        pose_row row;
        row.pose    = '{qx, qy, qz, qw, sx, sy, sz, px, py, pz};
        row.typed   = typed;
        row.diag[0] = d0;
        row.diag[1] = d1;
        row.diag[2] = d2;
        directed_rows.push_back(row);
    endtask

    task automatic drive_pose(pose_item it);
        i_quat_x  <= it.qx;
        i_quat_y  <= it.qy;
        i_quat_z  <= it.qz;
        i_quat_w  <= it.qw;
        i_scale_x <= it.sx;
        i_scale_y <= it.sy;
        i_scale_z <= it.sz;
        i_pos_x   <= it.px;
        i_pos_y   <= it.py;
        i_pos_z   <= it.pz;
    endtask

    task automatic send_pose(pose_item it);
        int gap;
        gap = quiet ? 0 : draw_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        drive_pose(it);
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic take_column_word();
        matrix_word want;
        if (words_due.size() == 0) begin
            $error("column word %0d arrived with nothing expected", o_column_index);
            mismatch_count++;
        end else begin
            want = words_due.pop_front();
            check_field("column_index", want.column, o_column_index);
            check_field("row0", want.row0, o_row0);
            check_field("row1", want.row1, o_row1);
            check_field("row2", want.row2, o_row2);
            check_field("row3", want.row3, o_row3);
            check_field("last_column", want.last, o_last_column);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) take_column_word();
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) < 3) begin
                stall_left <= draw_gap();
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        pose_item it;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        drive_pose('{default: '0});

        // identity, zero quaternion, half turns about each axis, then extremes
        add_row(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd256, 16'sd256, 16'sd256,
                32'h0, 32'h0, 32'h0, 1'b1, 32'sd65536, 32'sd65536, 32'sd65536);
        add_row(16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd256, 16'sd256, 16'sd256,
                32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                1'b1, 32'sd65536, 32'sd65536, 32'sd65536);
        add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h7fff, 16'h8000, 16'sd1,
                32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555,
                1'b1, 32'sd8388352, -32'sd8388608, 32'sd256);
        add_row(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256,
                32'h0001_0000, 32'h0, 32'h0, 1'b1, 32'sd65536, -32'sd65536, -32'sd65536);
        add_row(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256,
                32'h0, 32'hffff_0000, 32'h0, 1'b1, -32'sd65536, 32'sd65536, -32'sd65536);
        add_row(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd256, 16'sd256, 16'sd256,
                32'h0, 32'h0, 32'h0000_8000, 1'b1, -32'sd65536, -32'sd65536, 32'sd65536);
        add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                32'h0, 32'h0, 32'h0, 1'b1, 32'sd0, 32'sd0, 32'sd0);
        add_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0, '0, '0);
        add_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, '0, '0);
        add_row(16'h8000, 16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'h8000,
                32'h1234_5678, 32'h0, 32'h0, 1'b0, '0, '0, '0);
        add_row(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd256, 16'sd256, 16'sd256,
                32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, '0, '0, '0);
        add_row(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'haaaa,
                32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0, '0, '0);
        add_row(16'h7fff, 16'h8000, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'h7fff,
                32'h0, 32'h1, 32'hffff_fffe, 1'b0, '0, '0, '0);
        add_row(16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 16'sd512, -16'sd256, 16'sd128,
                32'h0010_0000, 32'hfff0_0000, 32'h0, 1'b0, '0, '0, '0);
        add_row(16'sd4096, -16'sd8192, 16'sd2048, 16'sd12000, -16'sd1, -16'sd1, -16'sd1,
                32'h0, 32'h0, 32'h0, 1'b0, '0, '0, '0);
        add_row(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0, '0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_pose(directed_rows[k].pose);
            if (directed_rows[k].typed) push_typed(directed_rows[k]);
            else predict_matrix(directed_rows[k].pose);
        end

        for (int n = 0; n < RANDOM_POSES; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            it = random_pose();
            send_pose(it);
            predict_matrix(it);
        end
        i_valid <= 1'b0;
        quiet = 1'b0;

        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/qstm_pkg.sv
hw/rtl/qstm_prod.sv
hw/rtl/qstm_scale.sv
hw/rtl/qstm_colser.sv
hw/rtl/quaternion_scale_translate_to_matrix.sv
hw/rtl/qstm_chk.sv
test/quaternion_scale_translate_to_matrix_test.sv
